FILE: rtl/pidpr_pkg.sv
`default_nettype none
package pidpr_pkg;

	// fixed field widths
	localparam int GAIN_W   = 15;
	localparam int DRIVE_W  = 14;
	localparam int OUT_W    = ((DRIVE_W + 7) / 8) * 8;
	localparam int INTEG_W  = 7;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = GAIN_W;

	localparam int INTEG_LIMIT = 50;
	localparam int DRIVE_LIMIT = 5000;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = CFG_IDX_W'(0),
		REG_PROP_GAIN  = CFG_IDX_W'(1),
		REG_INTEG_GAIN = CFG_IDX_W'(2),
		REG_DERIV_GAIN = CFG_IDX_W'(3)
	} reg_idx_t;

endpackage
`default_nettype wire

FILE: rtl/pid_power_regulator.sv
// An input transaction reaches its output transaction through the input
// register, then the arithmetic into the output register.
// Throughput: one sample pair per cycle unless the output stalls; integrator
// and previous-error registers close their loop in the single arithmetic stage.
// Reset (arst_n low, asynchronous): loop disabled, gains 1.0, integrator and
// previous error cleared, pipeline empty.
`default_nettype none
module pid_power_regulator #(
	parameter int SAMPLE_BITS    = 15,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// config write channel
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [pidpr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [pidpr_pkg::CFG_DATA_W-1:0]       cfg_data,
	// sample stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// s_tdata: setpoint [SAMPLE_BITS-1:0], measured above it, zero pad
	input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
	// drive stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// m_tdata: drive [13:0] (two's complement), zero pad [15:14]
	output logic [pidpr_pkg::OUT_W-1:0]                 m_tdata
);

	localparam int EW = SAMPLE_BITS + 1;                // error width
	localparam int GW = pidpr_pkg::GAIN_W;
	localparam int IW = pidpr_pkg::INTEG_W;
	localparam int SW = EW + GW + 3;                    // product sum width

	localparam logic signed [SW-1:0] TRUNC_BIAS =
		{{(SW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

	// ---------------------------------------------------------------
	// Configuration registers: always ready, unknown indexes dropped.
	// ---------------------------------------------------------------
	logic          enable_q;
	logic [GW-1:0] kp_q, ki_q, kd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			kp_q     <= pidpr_pkg::GAIN_RESET;
			ki_q     <= pidpr_pkg::GAIN_RESET;
			kd_q     <= pidpr_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (pidpr_pkg::reg_idx_t'(cfg_index))
				pidpr_pkg::REG_ENABLE:     enable_q <= cfg_data[0];
				pidpr_pkg::REG_PROP_GAIN:  kp_q     <= cfg_data[GW-1:0];
				pidpr_pkg::REG_INTEG_GAIN: ki_q     <= cfg_data[GW-1:0];
				pidpr_pkg::REG_DERIV_GAIN: kd_q     <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake. Stage 1 holds the accepted sample; it moves into the
	// output register whenever that register is empty or being drained.
	// Samples arriving while disabled are taken and dropped.
	// ---------------------------------------------------------------
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sp_s1, ms_s1;
	logic                   out_free;
	logic                   advance;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign advance  = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && enable_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sp_s1 <= s_tdata[SAMPLE_BITS-1:0];
			ms_s1 <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		end
	end

	// ---------------------------------------------------------------
	// PID arithmetic, one pass.
	// ---------------------------------------------------------------
	logic signed [IW-1:0]  integ_q;
	logic signed [EW-1:0]  prev_err_q;

	logic signed [EW-1:0]  err;
	logic signed [EW:0]    integ_raw;
	logic signed [IW-1:0]  integ_nxt;
	logic signed [EW:0]    deriv;
	logic signed [GW:0]    kp_s, ki_s, kd_s;
	logic signed [EW+GW:0] p_prop;
	logic signed [IW+GW:0] p_integ;
	logic signed [EW+GW+1:0] p_deriv;
	logic signed [SW-1:0]  sum;
	logic signed [SW-1:0]  sum_adj;
	logic signed [SW-1:0]  quo;
	logic signed [pidpr_pkg::DRIVE_W-1:0] drive;

	assign err = $signed(EW'(sp_s1)) - $signed(EW'(ms_s1));

	// integrator with clamp to +/-50
	assign integ_raw = (EW+1)'(integ_q) + (EW+1)'(err);
	always_comb begin
		if (integ_raw > pidpr_pkg::INTEG_LIMIT)
			integ_nxt = IW'(pidpr_pkg::INTEG_LIMIT);
		else if (integ_raw < -pidpr_pkg::INTEG_LIMIT)
			integ_nxt = IW'(-pidpr_pkg::INTEG_LIMIT);
		else
			integ_nxt = IW'(integ_raw);
	end

	assign deriv = (EW+1)'(err) - (EW+1)'(prev_err_q);

	assign kp_s = $signed({1'b0, kp_q});
	assign ki_s = $signed({1'b0, ki_q});
	assign kd_s = $signed({1'b0, kd_q});

	assign p_prop  = err * kp_s;
	assign p_integ = integ_nxt * ki_s;
	assign p_deriv = deriv * kd_s;

	assign sum = SW'(p_prop) + SW'(p_integ) + SW'(p_deriv);

	// drop fraction bits, rounding toward zero
	assign sum_adj = sum[SW-1] ? sum + TRUNC_BIAS : sum;
	assign quo     = sum_adj >>> GAIN_FRAC_BITS;

	always_comb begin
		if (quo > pidpr_pkg::DRIVE_LIMIT)
			drive = pidpr_pkg::DRIVE_W'(pidpr_pkg::DRIVE_LIMIT);
		else if (quo < -pidpr_pkg::DRIVE_LIMIT)
			drive = pidpr_pkg::DRIVE_W'(-pidpr_pkg::DRIVE_LIMIT);
		else
			drive = pidpr_pkg::DRIVE_W'(quo);
	end

	// loop state only moves when a sample is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
		end else if (advance) begin
			integ_q    <= integ_nxt;
			prev_err_q <= err;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= pidpr_pkg::OUT_W'({1'b0, drive} & {1'b0, {pidpr_pkg::DRIVE_W{1'b1}}});
		end
	end

endmodule
`default_nettype wire

FILE: rtl/pidpr_checker.sv
`default_nettype none
module pidpr_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tvalid,
	input wire logic                                s_tready,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [pidpr_pkg::OUT_W-1:0]         m_tdata
);

	logic signed [pidpr_pkg::DRIVE_W-1:0] drive;
	assign drive = $signed(m_tdata[pidpr_pkg::DRIVE_W-1:0]);

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// drive saturated to the limit
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (drive <= pidpr_pkg::DRIVE_LIMIT) && (drive >= -pidpr_pkg::DRIVE_LIMIT))
		else $error("drive out of range");

	// pad bits above drive stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[pidpr_pkg::OUT_W-1:pidpr_pkg::DRIVE_W] == '0)
		else $error("tdata pad bits not zero");

	// with an empty output register the input side never stalls
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind pid_power_regulator pidpr_checker u_pidpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
module testbench;

	localparam int GAIN_W = pidpr_pkg::GAIN_W;
	localparam int DRIVE_W = pidpr_pkg::DRIVE_W;
	localparam int OUT_W = pidpr_pkg::OUT_W;
	localparam int CFG_IDX_W = pidpr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = pidpr_pkg::CFG_DATA_W;
	localparam int INTEG_LIMIT = pidpr_pkg::INTEG_LIMIT;
	localparam int DRIVE_LIMIT = pidpr_pkg::DRIVE_LIMIT;

	localparam int SAMPLE_W = 15;
	localparam int FRAC_W = 8;
	localparam int IN_W = ((2 * SAMPLE_W + 7) / 8) * 8;
	localparam int GAIN_TOP = 25574;            // largest gain in the documented range
	localparam int GAIN_MAX = (1 << GAIN_W) - 1;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int QUIET_LIMIT = 3000;          // cycles with no transaction at all
	localparam int SETTLE_CYCLES = 4;           // pipeline is 2 deep, plus margin
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 250;
	localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG =
		CFG_IDX_W'(pidpr_pkg::REG_DERIV_GAIN + 1);
	localparam logic [CFG_IDX_W-1:0] LAST_REG_SLOT = {CFG_IDX_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic s_tvalid = 1'b0;
	logic s_tready;
	// setpoint [14:0], measured [29:15], zero pad [31:30]
	logic [IN_W-1:0] s_tdata = '0;

	logic m_tvalid;
	logic m_tready = 1'b0;
	// drive [13:0] two's complement, zero pad [15:14]
	logic [OUT_W-1:0] m_tdata;

	pid_power_regulator #(
		.SAMPLE_BITS(SAMPLE_W),
		.GAIN_FRAC_BITS(FRAC_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// ------------------------------------------------------------------
	// Controller shadow: registers as last written, loop state as of the
	// last sample accepted while enabled.
	// ------------------------------------------------------------------
	logic loop_on = 1'b0;
	longint kp = 256;
	longint ki = 256;
	longint kd = 256;
	longint integ_acc = 0;
	longint last_err = 0;

	logic [DRIVE_W-1:0] drive_q[$];   // drive values still owed by the block

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_req = 0;                 // receiver hold-off request, in cycles
	int live_items = 0;               // samples accepted while the loop ran
	int n_errors = 0;

	// One control step: error, clamped integral, derivative, weighted sum,
	// truncate toward zero, saturate. Only called for samples taken while on.
	function automatic logic [DRIVE_W-1:0] regulate(input logic [SAMPLE_W-1:0] sp,
			input logic [SAMPLE_W-1:0] ms);
		longint err;
		longint acc;
		longint dv;
		longint sum;
		longint q;
		err = longint'(sp) - longint'(ms);
		acc = integ_acc + err;
		if (acc > INTEG_LIMIT) acc = INTEG_LIMIT;
		if (acc < -INTEG_LIMIT) acc = -INTEG_LIMIT;
		integ_acc = acc;
		dv = err - last_err;
		last_err = err;
		sum = err * kp + acc * ki + dv * kd;
		// shift magnitude, not the signed value: floor would bias negatives
		if (sum < 0)
			q = -((-sum) >> FRAC_W);
		else
			q = sum >> FRAC_W;
		if (q > DRIVE_LIMIT) q = DRIVE_LIMIT;
		if (q < -DRIVE_LIMIT) q = -DRIVE_LIMIT;
		return q[DRIVE_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s at %0t: got %0d, want %0d", what, $time, got, want);
		n_errors++;
	endtask

	// ------------------------------------------------------------------
	// Result side: random ready, optional long hold-off, in-order compare.
	// ------------------------------------------------------------------
	int hold_left = 0;
	logic [DRIVE_W-1:0] want_drive;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (drive_q.size() == 0) begin
				report_mismatch("unexpected drive transaction",
					$signed(m_tdata[DRIVE_W-1:0]), 0);
			end else begin
				want_drive = drive_q.pop_front();
				if (m_tdata[DRIVE_W-1:0] !== want_drive)
					report_mismatch("drive", $signed(m_tdata[DRIVE_W-1:0]),
						$signed(want_drive));
				if (m_tdata[OUT_W-1:DRIVE_W] !== '0)
					report_mismatch("drive pad bits", m_tdata[OUT_W-1:DRIVE_W], 0);
			end
		end
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Watchdog: any accepted transaction on any channel resets the count.
	int quiet = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Shared driving tasks. All of them start and end right after a
	// rising edge.
	// ------------------------------------------------------------------

	// Register write; shadow follows the same masking as the block.
	// After each write the task idles with valid low before returning.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pidpr_pkg::REG_ENABLE: loop_on = val[0];
			pidpr_pkg::REG_PROP_GAIN: kp = val;
			pidpr_pkg::REG_INTEG_GAIN: ki = val;
			pidpr_pkg::REG_DERIV_GAIN: kd = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// One sample pair. Leaves tvalid high so back-to-back items need no
	// bubble; whoever stops sending drops it.
	task automatic send_sample(input logic [SAMPLE_W-1:0] sp, input logic [SAMPLE_W-1:0] ms);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - 2 * SAMPLE_W){1'b0}}, ms, sp};
		do @(posedge clk); while (!s_tready);
		if (loop_on) begin
			drive_q.push_back(regulate(sp, ms));
			live_items++;
		end
	endtask

	// Stop sending, let every owed drive value come out, then give the
	// pipeline time to finish samples that produce nothing (loop off).
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(7))
			0: return '0;
			1: return GAIN_W'(GAIN_TOP);
			2: return GAIN_W'($urandom_range(GAIN_MAX, GAIN_TOP + 1));
			3: return GAIN_W'($urandom_range(512));
			default: return GAIN_W'($urandom_range(GAIN_TOP));
		endcase
	endfunction

	// Mostly a tracking loop: measured within 80 of the setpoint, clipped to
	// the sample range. Some wild pairs.
	task automatic send_random_sample();
		int sp;
		int ms;
		sp = $urandom_range(SAMPLE_MAX);
		case ($urandom_range(9))
			0: ms = $urandom_range(SAMPLE_MAX);
			1: begin
				sp = $urandom_range(1) ? SAMPLE_MAX : 0;
				ms = $urandom_range(1) ? SAMPLE_MAX : 0;
			end
			default: begin
				ms = sp + $urandom_range(160) - 80;
				if (ms < 0) ms = 0;
				if (ms > SAMPLE_MAX) ms = SAMPLE_MAX;
			end
		endcase
		send_sample(SAMPLE_W'(sp), SAMPLE_W'(ms));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset the loop is off: samples vanish. Then turn it on with
	// the reset gains and hit error extremes, both integral clamps and
	// both output rails.
	task automatic test_reset_defaults();
		send_sample(SAMPLE_W'(1000), SAMPLE_W'(0));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(SAMPLE_MAX));
		wait_idle();
		write_reg(pidpr_pkg::REG_ENABLE, CFG_DATA_W'(1));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(0));
		send_sample(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(0));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(40), SAMPLE_W'(0));
		send_sample(SAMPLE_W'(40), SAMPLE_W'(0));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(25));
		send_sample(SAMPLE_W'(12345), SAMPLE_W'(12300));
		wait_idle();
	endtask

	// Zero gains, gains past the nominal top, and a tiny gain where the
	// sum is a small negative fraction that must truncate to zero.
	task automatic test_gain_extremes();
		write_reg(pidpr_pkg::REG_PROP_GAIN, '0);
		write_reg(pidpr_pkg::REG_INTEG_GAIN, '0);
		write_reg(pidpr_pkg::REG_DERIV_GAIN, '0);
		send_sample(SAMPLE_W'(500), SAMPLE_W'(0));
		wait_idle();
		write_reg(pidpr_pkg::REG_PROP_GAIN, GAIN_W'(GAIN_MAX));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(3), SAMPLE_W'(0));
		wait_idle();
		write_reg(pidpr_pkg::REG_PROP_GAIN, GAIN_W'(1));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(1));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(255));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(257));
		wait_idle();
		write_reg(pidpr_pkg::REG_PROP_GAIN, GAIN_W'(GAIN_TOP));
		write_reg(pidpr_pkg::REG_INTEG_GAIN, GAIN_W'(GAIN_TOP));
		write_reg(pidpr_pkg::REG_DERIV_GAIN, GAIN_W'(GAIN_TOP));
		send_sample(SAMPLE_W'(200), SAMPLE_W'(100));
		send_sample(SAMPLE_W'(100), SAMPLE_W'(200));
		wait_idle();
	endtask

	// Writes to unused slots change nothing; enable looks at bit 0 only;
	// loop state survives a disabled stretch untouched.
	task automatic test_register_map();
		write_reg(FIRST_UNUSED_REG, CFG_DATA_W'(GAIN_MAX));
		write_reg(LAST_REG_SLOT, CFG_DATA_W'($urandom_range(GAIN_MAX)));
		send_sample(SAMPLE_W'(70), SAMPLE_W'(60));
		wait_idle();
		write_reg(pidpr_pkg::REG_ENABLE, CFG_DATA_W'(GAIN_MAX - 1));
		send_sample(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(0));
		send_sample(SAMPLE_W'(0), SAMPLE_W'(SAMPLE_MAX));
		wait_idle();
		write_reg(pidpr_pkg::REG_ENABLE, CFG_DATA_W'(GAIN_MAX));
		send_sample(SAMPLE_W'(65), SAMPLE_W'(60));
		send_sample(SAMPLE_W'(60), SAMPLE_W'(65));
		wait_idle();
	endtask

	// Random traffic under one idling profile. Between short bursts the
	// block drains and one register write goes out, sometimes to an unused slot.
	task automatic test_random_traffic(input int src_pct, input int snk_pct);
		int start;
		int burst;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		start = live_items;
		while (live_items - start < PHASE_ITEMS) begin
			wait_idle();
			case ($urandom_range(9))
				0: write_reg(pidpr_pkg::REG_ENABLE,
					CFG_DATA_W'({$urandom_range(GAIN_MAX >> 1), 1'b0}));
				1: write_reg(CFG_IDX_W'($urandom_range(LAST_REG_SLOT, FIRST_UNUSED_REG)),
					CFG_DATA_W'($urandom_range(GAIN_MAX)));
				2: write_reg(pidpr_pkg::REG_PROP_GAIN, pick_gain());
				3: write_reg(pidpr_pkg::REG_INTEG_GAIN, pick_gain());
				4: write_reg(pidpr_pkg::REG_DERIV_GAIN, pick_gain());
				default: write_reg(pidpr_pkg::REG_ENABLE,
					CFG_DATA_W'({$urandom_range(GAIN_MAX >> 1), 1'b1}));
			endcase
			burst = loop_on ? $urandom_range(60, 10) : $urandom_range(6, 2);
			repeat (burst) send_random_sample();
		end
		wait_idle();
	endtask

	// Receiver stalls long enough for the block to fill and push back on
	// its input while samples keep coming; afterwards the sender pauses
	// until everything is out and resumes with the same loop state.
	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(pidpr_pkg::REG_ENABLE, CFG_DATA_W'(1));
		write_reg(pidpr_pkg::REG_PROP_GAIN, pidpr_pkg::GAIN_RESET);
		write_reg(pidpr_pkg::REG_INTEG_GAIN, pidpr_pkg::GAIN_RESET);
		write_reg(pidpr_pkg::REG_DERIV_GAIN, pidpr_pkg::GAIN_RESET);
		hold_req = HOLD_CYCLES;
		repeat (40) send_random_sample();
		wait_idle();
		repeat (10) send_random_sample();
		wait_idle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_gain_extremes();
		test_register_map();
		test_random_traffic(10, 87);
		test_random_traffic(87, 10);
		test_random_traffic(0, 0);
		test_backpressure();

		wait_idle();
		repeat (8) @(posedge clk);
		if (n_errors == 0 && drive_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
